// ===== rtl/daa_pkg.sv =====
// Package: shared constants, types and codes for the deadlock-avoidance allocator.
`timescale 1ns / 1ps
package daa_pkg;
    localparam int CUSTOMERS_DEF = 8;
    localparam int RESOURCE_TYPES_DEF = 4;
    localparam int MAX_RES = 4;
    localparam int UNIT_W = 8;
    localparam int CUST_W = 3;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int NUM_REGS = 4;

    typedef logic [UNIT_W-1:0] unit_t;

    localparam logic [FUNC_W-1:0] FUNC_SETMAX  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_AVAIL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNSAFE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic do_init;   // load available, clear tables
        logic do_setmax;
        logic do_release;
        logic do_grant;  // apply tentative grant, start work vector
        logic do_check;  // examine the row at the scan pointer
        logic new_pass;  // clear progress flag, restart scan
        logic rollback;
    } daa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cust_ok;
        logic [STAT_W-1:0] pre_status; // per-resource check result
        logic              all_done;
        logic              last_row;
        logic              progress;
    } daa_sts_t;
endpackage

// ===== rtl/daa_if.sv =====
// Interfaces: valid/ready channels for operation items and status results.
`timescale 1ns / 1ps
interface daa_op_if;
    import daa_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CUST_W-1:0] customer;
    logic [UNIT_W-1:0] amount_0;
    logic [UNIT_W-1:0] amount_1;
    logic [UNIT_W-1:0] amount_2;
    logic [UNIT_W-1:0] amount_3;
    modport source (output valid, func, customer, amount_0, amount_1, amount_2, amount_3,
                    input ready);
    modport sink (input valid, func, customer, amount_0, amount_1, amount_2, amount_3,
                  output ready);
endinterface

interface daa_res_if;
    import daa_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

// ===== rtl/daa_datapath.sv =====
// Datapath: available vector, maximum and allocation rows, work vector and scan pointer.
`timescale 1ns / 1ps
module daa_datapath
    import daa_pkg::*;
#(
    parameter int CUSTOMERS = CUSTOMERS_DEF,
    parameter int RESOURCE_TYPES = RESOURCE_TYPES_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  daa_cmd_t          cmd,
    output daa_sts_t          sts,
    input  logic [FUNC_W-1:0] in_func,
    input  logic [CUST_W-1:0] in_cust,
    input  unit_t             in_amt [MAX_RES],
    input  unit_t             init_av [MAX_RES]
);
    localparam int PW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int WW = UNIT_W + 5;

    unit_t                max_reg   [CUSTOMERS][RESOURCE_TYPES];
    unit_t                alloc_reg [CUSTOMERS][RESOURCE_TYPES];
    unit_t                avail_reg [RESOURCE_TYPES];
    unit_t                amt_reg   [RESOURCE_TYPES];
    logic [WW-1:0]        work_reg  [RESOURCE_TYPES];
    logic [CUSTOMERS-1:0] done_reg;
    logic [FUNC_W-1:0]    func_reg;
    logic [CUST_W-1:0]    cust_reg;
    logic [PW-1:0]        ptr_reg;
    logic                 prog_reg;

    logic          cust_ok;
    logic [PW-1:0] ci;
    logic          fits;
    logic [STAT_W-1:0] pre;

    assign cust_ok = int'(cust_reg) < CUSTOMERS;
    assign ci = PW'(cust_reg);

    // Row fit test at the scan pointer, all resources in parallel
    always_comb
    begin
        fits = !done_reg[ptr_reg];
        for (int r = 0; r < RESOURCE_TYPES; r++)
        begin
            if ({1'b0, max_reg[ptr_reg][r]} > {1'b0, alloc_reg[ptr_reg][r]} &&
                WW'(max_reg[ptr_reg][r] - alloc_reg[ptr_reg][r]) > work_reg[r])
                fits = 1'b0;
        end
    end

    // Per-resource request checks in index order, first failure wins
    always_comb
    begin
        pre = ST_OK;
        for (int r = RESOURCE_TYPES-1; r >= 0; r--)
        begin
            if (amt_reg[r] > avail_reg[r])
                pre = ST_AVAIL;
            else if ({1'b0, alloc_reg[ci][r]} + {1'b0, amt_reg[r]} > {1'b0, max_reg[ci][r]})
                pre = ST_NEED;
        end
    end

    always_comb
    begin
        sts.func = func_reg;
        sts.cust_ok = cust_ok;
        sts.pre_status = pre;
        sts.all_done = &done_reg;
        sts.last_row = ptr_reg == PW'(CUSTOMERS-1);
        sts.progress = prog_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CUSTOMERS; c++)
                for (int r = 0; r < RESOURCE_TYPES; r++)
                begin
                    max_reg[c][r] <= '0;
                    alloc_reg[c][r] <= '0;
                end
            for (int r = 0; r < RESOURCE_TYPES; r++)
            begin
                avail_reg[r] <= '0;
                amt_reg[r] <= '0;
                work_reg[r] <= '0;
            end
            func_reg <= '0;
            cust_reg <= '0;
            done_reg <= '0;
            ptr_reg <= '0;
            prog_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg <= in_func;
                cust_reg <= in_cust;
                for (int r = 0; r < RESOURCE_TYPES; r++)
                    amt_reg[r] <= in_amt[r];
            end
            if (cmd.do_init)
            begin
                for (int r = 0; r < RESOURCE_TYPES; r++)
                    avail_reg[r] <= init_av[r];
                for (int c = 0; c < CUSTOMERS; c++)
                    for (int r = 0; r < RESOURCE_TYPES; r++)
                    begin
                        max_reg[c][r] <= '0;
                        alloc_reg[c][r] <= '0;
                    end
            end
            if (cmd.do_setmax)
                for (int r = 0; r < RESOURCE_TYPES; r++)
                    max_reg[ci][r] <= amt_reg[r];
            if (cmd.do_release)
                for (int r = 0; r < RESOURCE_TYPES; r++)
                begin
                    if (amt_reg[r] > alloc_reg[ci][r])
                    begin
                        avail_reg[r] <= avail_reg[r] + alloc_reg[ci][r];
                        alloc_reg[ci][r] <= '0;
                    end
                    else
                    begin
                        avail_reg[r] <= avail_reg[r] + amt_reg[r];
                        alloc_reg[ci][r] <= alloc_reg[ci][r] - amt_reg[r];
                    end
                end
            // Tentative grant; work vector starts from the new available
            if (cmd.do_grant)
            begin
                for (int r = 0; r < RESOURCE_TYPES; r++)
                begin
                    avail_reg[r] <= avail_reg[r] - amt_reg[r];
                    alloc_reg[ci][r] <= alloc_reg[ci][r] + amt_reg[r];
                    work_reg[r] <= WW'(avail_reg[r] - amt_reg[r]);
                end
                done_reg <= '0;
                ptr_reg <= '0;
                prog_reg <= 1'b0;
            end
            if (cmd.new_pass)
            begin
                ptr_reg <= '0;
                prog_reg <= 1'b0;
            end
            // One row per cycle within a pass; a finishing row frees its allocation at once
            if (cmd.do_check)
            begin
                if (fits)
                begin
                    done_reg[ptr_reg] <= 1'b1;
                    prog_reg <= 1'b1;
                    for (int r = 0; r < RESOURCE_TYPES; r++)
                        work_reg[r] <= work_reg[r] + WW'(alloc_reg[ptr_reg][r]);
                end
                if (ptr_reg != PW'(CUSTOMERS-1))
                    ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.rollback)
                for (int r = 0; r < RESOURCE_TYPES; r++)
                begin
                    avail_reg[r] <= avail_reg[r] + amt_reg[r];
                    alloc_reg[ci][r] <= alloc_reg[ci][r] - amt_reg[r];
                end
        end
    end
endmodule

// ===== rtl/daa_ctrl.sv =====
// Controller: sequences each operation and the safety-check passes.
`timescale 1ns / 1ps
module daa_ctrl
    import daa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] out_status,
    output daa_cmd_t          cmd,
    input  daa_sts_t          sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_RESP;
    assign out_status = stat_reg;

    always_comb
    begin
        state_next = state_reg;
        stat_next = stat_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                stat_next = ST_OK;
                state_next = S_RESP;
                if (sts.func == FUNC_INIT)
                    cmd.do_init = 1'b1;
                else if (sts.cust_ok)
                begin
                    case (sts.func)
                        FUNC_SETMAX:  cmd.do_setmax = 1'b1;
                        FUNC_RELEASE: cmd.do_release = 1'b1;
                        default:
                        begin
                            if (sts.pre_status != ST_OK)
                                stat_next = sts.pre_status;
                            else
                            begin
                                cmd.do_grant = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.do_check = 1'b1;
                if (sts.last_row)
                    state_next = S_PASS;
            end
            // End of a pass: safe, unsafe, or another pass
            S_PASS:
            begin
                if (sts.all_done)
                    state_next = S_RESP;
                else if (!sts.progress)
                begin
                    cmd.rollback = 1'b1;
                    stat_next = ST_UNSAFE;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.new_pass = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg <= stat_next;
        end
    end
endmodule

// ===== rtl/deadlock_avoidance_allocator_top.sv =====
// Top level: Banker's algorithm allocator with APB configuration port.
//
// channel | dir | payload                                  | transfer
// op      | in  | func, customer, amount_0..amount_3       | valid && ready
// res     | out | status                                   | valid && ready
// apb     | in  | paddr[3:0], pwdata[31:0], prdata[31:0]   | psel && penable && pwrite
//
// Set maximum, release, initialize and failed requests: the input item is registered, the EXEC
// state applies the operation, and the result is then offered from the RESP state.
// A checked request adds up to CUSTOMERS passes of CUSTOMERS row checks, each pass closed
// by the PASS state, one row at a time through the single-row fit comparator.
// One item at a time; a new item is taken after the result has been transferred.
// Reset clears the tables, the available vector and the registers at once.
`timescale 1ns / 1ps
module deadlock_avoidance_allocator_top
    import daa_pkg::*;
#(
    parameter int CUSTOMERS = CUSTOMERS_DEF,
    parameter int RESOURCE_TYPES = RESOURCE_TYPES_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    daa_op_if.sink      op,
    daa_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    unit_t    cfg_reg [NUM_REGS];
    unit_t    amt [MAX_RES];
    daa_cmd_t cmd;
    daa_sts_t sts;
    logic     wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (wr && paddr[1:0] == 2'b00)
            cfg_reg[paddr[3:2]] <= pwdata[UNIT_W-1:0];
    end

    assign prdata = (paddr[1:0] == 2'b00) ? {24'd0, cfg_reg[paddr[3:2]]} : 32'd0;

    assign amt[0] = op.amount_0;
    assign amt[1] = op.amount_1;
    assign amt[2] = op.amount_2;
    assign amt[3] = op.amount_3;

    daa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(op.valid), .in_ready(op.ready),
        .out_valid(res.valid), .out_ready(res.ready), .out_status(res.status),
        .cmd(cmd), .sts(sts)
    );

    daa_datapath #(.CUSTOMERS(CUSTOMERS), .RESOURCE_TYPES(RESOURCE_TYPES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_func(op.func), .in_cust(op.customer), .in_amt(amt), .init_av(cfg_reg)
    );

    // Never take an item while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.ready && res.valid)) else $error("input taken while result pending");
    // A transfer in is never directly followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (op.valid && op.ready) |=> !res.valid) else $error("result too early");
    // At most one of the init, set-maximum, release, grant, check and rollback commands at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_init, cmd.do_setmax, cmd.do_release, cmd.do_grant,
                  cmd.do_check, cmd.rollback})) else $error("conflicting commands");
endmodule
